/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fir_pkg.sv */
package fir_pkg;

    localparam int TAPS_DEFAULT = 64;

    localparam int OPCODE_W     = 2;
    localparam int COEF_INDEX_W = 6;
    localparam int COEF_W       = 18;
    localparam int SAMPLE_W     = 16;
    localparam int TAP_COUNT_W  = 7;
    localparam int PROD_W       = COEF_W + SAMPLE_W;
    localparam int FRAC_BITS    = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_DONE
    } state_t;

endpackage

/* rtl/fir_filter.sv */
// Direct-form FIR filter over a TAPS-deep sample history and a TAPS-entry
// coefficient table (signed Q2.16), both held in synchronous memories and
// walked by one shared multiply-accumulate, one tap per cycle. Items are
// taken one at a time. A sample item with n active taps (n = tap_count,
// capped at TAPS) reads n entries from each memory, then drains the read,
// multiply and accumulate stages, rounds the sum and loads the result
// register before the next item is taken. Load, clear and unused-opcode
// items, and samples with tap_count 0, go straight to loading the result
// register. A result that is still waiting holds the block until the
// result register frees. The history memory is a circular buffer with a
// fill count, so a clear item costs no sweep. After reset the coefficient
// memory is cleared entry by entry before the first item is accepted.
// tap_count writes are taken at any time. Every item returns one result;
// filtered and clipped hold the last computed output, fresh marks a newly
// computed one. Results wait in an output register while the next item
// is accepted.
module fir_filter #(
    parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fir_pkg::TAP_COUNT_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [fir_pkg::OPCODE_W-1:0]           opcode,
    input  logic [fir_pkg::COEF_INDEX_W-1:0]       coef_index,
    input  logic signed [fir_pkg::COEF_W-1:0]      coef_value,
    input  logic signed [fir_pkg::SAMPLE_W-1:0]    sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [fir_pkg::SAMPLE_W-1:0]    filtered,
    output logic                                   clipped,
    output logic                                   fresh
);

    localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW     = $clog2(TAPS + 1);
    localparam int ACCW   = fir_pkg::PROD_W + $clog2(TAPS) + 1;
    localparam int COEF_W = fir_pkg::COEF_W;
    localparam int SMP_W  = fir_pkg::SAMPLE_W;

    localparam logic signed [ACCW:0] ROUND_BIAS = (ACCW + 1)'(1 << (fir_pkg::FRAC_BITS - 1));
    localparam logic signed [ACCW:0] Y_MAX      = (ACCW + 1)'((1 << (SMP_W - 1)) - 1);
    localparam logic signed [ACCW:0] Y_MIN      = -((ACCW + 1)'(1 << (SMP_W - 1)));

    fir_pkg::state_t state_reg, state_next;

    logic [fir_pkg::TAP_COUNT_W-1:0] tap_reg;
    logic [AW-1:0]                   ptr_reg, ptr_next;
    logic [CW-1:0]                   fill_reg, fill_next;
    logic [CW-1:0]                   init_cnt_reg, init_cnt_next;
    logic [CW-1:0]                   rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0]                   n_reg, n_next;
    logic [AW-1:0]                   hist_addr_reg, hist_addr_next;
    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_mask_reg, s1_mask_next;
    logic                            s2_valid_reg, s2_valid_next;
    logic signed [fir_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACCW-1:0]          acc_reg, acc_next;
    logic signed [SMP_W-1:0]         last_out_reg, last_out_next;
    logic                            last_clip_reg, last_clip_next;
    logic                            fresh_reg, fresh_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [SMP_W-1:0]         filtered_reg, filtered_next;
    logic                            clipped_reg, clipped_next;
    logic                            fresh_out_reg, fresh_out_next;

    logic [CW-1:0]                   n_cfg;
    logic [AW-1:0]                   ptr_adv;
    logic                            hist_we;
    logic                            coef_we;
    logic [AW-1:0]                   coef_waddr;
    logic signed [COEF_W-1:0]        coef_wdata;
    logic                            rd_en;
    logic signed [SMP_W-1:0]         hist_rd;
    logic signed [COEF_W-1:0]        coef_rd;
    logic signed [ACCW:0]            biased;
    logic signed [ACCW:0]            y_wide;

    fir_ram #(
        .WIDTH (SMP_W),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (ptr_adv),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (hist_addr_reg),
        .rd_data (hist_rd)
    );

    fir_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (coef_waddr),
        .wr_data (coef_wdata),
        .rd_en   (rd_en),
        .rd_addr (AW'(rd_cnt_reg)),
        .rd_data (coef_rd)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == fir_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign clipped   = clipped_reg;
    assign fresh     = fresh_out_reg;

    assign n_cfg   = (32'(tap_reg) > TAPS) ? CW'(TAPS) : CW'(tap_reg);
    assign ptr_adv = (ptr_reg == AW'(TAPS - 1)) ? '0 : ptr_reg + 1'b1;
    assign biased  = (ACCW + 1)'(acc_reg) + ROUND_BIAS;
    assign y_wide  = biased >>> fir_pkg::FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fir_pkg::ST_INIT;
            tap_reg       <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            init_cnt_reg  <= '0;
            rd_cnt_reg    <= '0;
            n_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            last_out_reg  <= '0;
            last_clip_reg <= 1'b0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                tap_reg <= cfg_data;
            end
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            init_cnt_reg  <= init_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            n_reg         <= n_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            last_out_reg  <= last_out_next;
            last_clip_reg <= last_clip_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_addr_reg <= hist_addr_next;
        s1_mask_reg   <= s1_mask_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        filtered_reg  <= filtered_next;
        clipped_reg   <= clipped_next;
        fresh_out_reg <= fresh_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        init_cnt_next  = init_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        n_next         = n_reg;
        hist_addr_next = hist_addr_reg;
        s1_valid_next  = 1'b0;
        s1_mask_next   = s1_mask_reg;
        s2_valid_next  = s1_valid_reg;
        prod_next      = '0;
        acc_next       = s2_valid_reg ? acc_reg + ACCW'(prod_reg) : acc_reg;
        last_out_next  = last_out_reg;
        last_clip_next = last_clip_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;
        clipped_next   = clipped_reg;
        fresh_out_next = fresh_out_reg;
        hist_we        = 1'b0;
        coef_we        = 1'b0;
        coef_waddr     = AW'(coef_index);
        coef_wdata     = coef_value;
        rd_en          = 1'b0;

        if (s1_mask_reg)
        begin
            prod_next = coef_rd * hist_rd;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fir_pkg::ST_INIT:
            begin
                coef_we       = 1'b1;
                coef_waddr    = AW'(init_cnt_reg);
                coef_wdata    = '0;
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == CW'(TAPS - 1))
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            fir_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    fresh_next  = 1'b0;
                    acc_next    = '0;
                    rd_cnt_next = '0;
                    state_next  = fir_pkg::ST_DONE;
                    case (opcode)
                        fir_pkg::OP_SAMPLE:
                        begin
                            if (n_cfg != '0)
                            begin
                                hist_we        = 1'b1;
                                ptr_next       = ptr_adv;
                                hist_addr_next = ptr_adv;
                                fill_next      = (fill_reg == CW'(TAPS)) ? fill_reg
                                                                         : fill_reg + 1'b1;
                                n_next         = n_cfg;
                                state_next     = fir_pkg::ST_MAC;
                            end
                        end
                        fir_pkg::OP_LOAD:
                        begin
                            coef_we = (32'(coef_index) < TAPS);
                        end
                        fir_pkg::OP_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fir_pkg::ST_MAC:
            begin
                if (rd_cnt_reg != n_reg)
                begin
                    rd_en          = 1'b1;
                    rd_cnt_next    = rd_cnt_reg + 1'b1;
                    hist_addr_next = (hist_addr_reg == '0) ? AW'(TAPS - 1)
                                                           : hist_addr_reg - 1'b1;
                    s1_valid_next  = 1'b1;
                    s1_mask_next   = (rd_cnt_reg < fill_reg);
                end
                else if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = fir_pkg::ST_ROUND;
                end
            end
            fir_pkg::ST_ROUND:
            begin
                if (y_wide > Y_MAX)
                begin
                    last_out_next  = SMP_W'(Y_MAX);
                    last_clip_next = 1'b1;
                end
                else if (y_wide < Y_MIN)
                begin
                    last_out_next  = SMP_W'(Y_MIN);
                    last_clip_next = 1'b1;
                end
                else
                begin
                    last_out_next  = SMP_W'(y_wide);
                    last_clip_next = 1'b0;
                end
                fresh_next = 1'b1;
                state_next = fir_pkg::ST_DONE;
            end
            fir_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    filtered_next  = last_out_reg;
                    clipped_next   = last_clip_reg;
                    fresh_out_next = fresh_reg;
                    state_next     = fir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir_pkg::ST_INIT;
            end
        endcase
    end

endmodule

/* rtl/fir_ram.sv */
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/fir_chk.sv */
`include "assert_macros.svh"

module fir_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [fir_pkg::SAMPLE_W-1:0] filtered,
    input logic                                clipped,
    input logic                                fresh
);

    logic signed [fir_pkg::SAMPLE_W-1:0] prev_filt_reg;
    logic                                prev_clip_reg;
    logic                                out_stall;
    logic [fir_pkg::SAMPLE_W+1:0]        out_word;
    logic                                out_held;
    logic                                at_rail;

    assign out_stall = out_valid && !out_ready;
    assign out_word  = {filtered, clipped, fresh};
    assign out_held  = (filtered == prev_filt_reg) && (clipped == prev_clip_reg);
    assign at_rail   = (filtered == 16'sh7fff) || (filtered == -16'sh8000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_filt_reg <= '0;
            prev_clip_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            prev_filt_reg <= filtered;
            prev_clip_reg <= clipped;
        end
    end

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")

    // take one item at a time
    `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")

    // a result that is not fresh repeats the held output
    `ASSERT_ALWAYS(a_held, !(out_valid && !fresh) || out_held, "held output changed")

    // a clipped output sits at a rail
    `ASSERT_ALWAYS(a_clip_rail, !(out_valid && clipped) || at_rail, "clipped output off the rail")

endmodule

bind fir_filter fir_chk u_fir_chk (.*);
